// File: src/rdd_pkg.sv
// ----------------------------------------------------------------------------
// rdd_pkg
// Shared types, rule codes and calendar helpers for the days-until-date core.
// ----------------------------------------------------------------------------
`default_nettype none

package rdd_pkg;

    // Repeat rules carried on the op field.
    localparam logic [1:0] OP_ONCE    = 2'd0;
    localparam logic [1:0] OP_WEEKLY  = 2'd1;
    localparam logic [1:0] OP_MONTHLY = 2'd2;
    localparam logic [1:0] OP_YEARLY  = 2'd3;

    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_DEC = 4'd12;

    localparam logic [2:0] WEEKDAY_SUN = 3'd7;

    // Reciprocal of 100 scaled by 2^19; exact for operands below 43690.
    localparam int unsigned RECIP100  = 5243;
    localparam int unsigned RECIP_SHF = 19;

    localparam logic signed [22:0] DAYS_MAX = 23'sh3FFFFF;
    localparam logic signed [22:0] DAYS_MIN = 23'sh400000;

    // A year one past the input range fits in 15 bits.
    typedef logic [14:0]        year_t;
    typedef logic [3:0]         month_t;
    typedef logic [4:0]         day_t;
    typedef logic [2:0]         wday_t;
    typedef logic [22:0]        ord_t;
    typedef logic signed [22:0] days_t;

    // Rule, current date and the due date picked by the first stage, plus the weekly answer.
    typedef struct packed {
        logic [1:0] op;
        year_t      cur_year;
        month_t     cur_month;
        day_t       cur_day;
        year_t      due_year;
        month_t     due_month;
        day_t       due_day;
        wday_t      week_days;
    } sel_t;

    function automatic month_t fix_month(input month_t m);
        month_t r;
        if (m < MONTH_JAN)
        begin
            r = MONTH_JAN;
        end
        else if (m > MONTH_DEC)
        begin
            r = MONTH_DEC;
        end
        else
        begin
            r = m;
        end
        return r;
    endfunction

    // Days in the common year before the first of the given month.
    function automatic logic [8:0] cum_days(input month_t m);
        logic [8:0] r;
        unique case (m)
            4'd1:    r = 9'd0;
            4'd2:    r = 9'd31;
            4'd3:    r = 9'd59;
            4'd4:    r = 9'd90;
            4'd5:    r = 9'd120;
            4'd6:    r = 9'd151;
            4'd7:    r = 9'd181;
            4'd8:    r = 9'd212;
            4'd9:    r = 9'd243;
            4'd10:   r = 9'd273;
            4'd11:   r = 9'd304;
            4'd12:   r = 9'd334;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// File: src/rdd_select.sv
// ----------------------------------------------------------------------------
// rdd_select
// First stage: cleans up months, picks the due date for the repeat rule and
// works out the weekly distance.
// ----------------------------------------------------------------------------
`default_nettype none

module rdd_select
(
    input  wire logic           clk,
    input  wire logic           load,
    input  wire logic [1:0]     op,
    input  wire logic [13:0]    cur_year,
    input  wire logic [3:0]     cur_month,
    input  wire logic [4:0]     cur_day,
    input  wire logic [2:0]     cur_weekday,
    input  wire logic [13:0]    tgt_year,
    input  wire logic [3:0]     tgt_month,
    input  wire logic [4:0]     tgt_day,
    input  wire logic [2:0]     tgt_weekday,
    output rdd_pkg::sel_t       sel_reg
);

    typedef logic [2:0] wday_mod_t;

    rdd_pkg::sel_t   sel_next;
    rdd_pkg::month_t cm;
    rdd_pkg::month_t tm;
    rdd_pkg::year_t  cy;
    wday_mod_t       cw;
    wday_mod_t       tw;
    logic signed [3:0] wdiff;

    always_comb
    begin
        cm = rdd_pkg::fix_month(cur_month);
        tm = rdd_pkg::fix_month(tgt_month);
        cy = {1'b0, cur_year};
        // Sunday may come as 7 or 0; both are zero modulo seven.
        cw = (cur_weekday == rdd_pkg::WEEKDAY_SUN) ? 3'd0 : cur_weekday;
        tw = (tgt_weekday == rdd_pkg::WEEKDAY_SUN) ? 3'd0 : tgt_weekday;
        wdiff = signed'({1'b0, tw}) - signed'({1'b0, cw});

        sel_next.op        = op;
        sel_next.cur_year  = cy;
        sel_next.cur_month = cm;
        sel_next.cur_day   = cur_day;
        sel_next.due_year  = {1'b0, tgt_year};
        sel_next.due_month = tm;
        sel_next.due_day   = tgt_day;
        sel_next.week_days = (wdiff < 0) ? 3'(wdiff + 4'sd7) : 3'(wdiff);

        unique case (op)
            rdd_pkg::OP_MONTHLY:
            begin
                sel_next.due_year  = cy;
                sel_next.due_month = cm;
                if (cur_day > tgt_day)
                begin
                    if (cm == rdd_pkg::MONTH_DEC)
                    begin
                        sel_next.due_year  = cy + 15'd1;
                        sel_next.due_month = rdd_pkg::MONTH_JAN;
                    end
                    else
                    begin
                        sel_next.due_month = cm + 4'd1;
                    end
                end
            end
            rdd_pkg::OP_YEARLY:
            begin
                if (cm > tm || (cm == tm && cur_day > tgt_day))
                begin
                    sel_next.due_year = cy + 15'd1;
                end
                else
                begin
                    sel_next.due_year = cy;
                end
            end
            rdd_pkg::OP_ONCE,
            rdd_pkg::OP_WEEKLY:
            begin
                sel_next.due_year = {1'b0, tgt_year};
            end
            default:
            begin
                sel_next.due_year = {1'b0, tgt_year};
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sel_reg <= sel_next;
        end
    end

endmodule

`default_nettype wire

// File: src/rdd_ordinal.sv
// ----------------------------------------------------------------------------
// rdd_ordinal
// Two-stage day ordinal: year terms and month offset first, then the leap
// test and the final sum.
// ----------------------------------------------------------------------------
`default_nettype none

module rdd_ordinal
(
    input  wire logic            clk,
    input  wire logic            load_a,
    input  wire logic            load_b,
    input  wire rdd_pkg::year_t  year,
    input  wire rdd_pkg::month_t month,
    input  wire rdd_pkg::day_t   day,
    output rdd_pkg::ord_t        ord_reg
);

    // Stage A registers.
    rdd_pkg::ord_t   y365_reg;
    logic [12:0]     q4_reg;
    logic [7:0]      q100_reg;
    logic [5:0]      q400_reg;
    logic [7:0]      qy100_reg;
    rdd_pkg::year_t  year_reg;
    logic [8:0]      cum_reg;
    logic            late_reg;
    rdd_pkg::day_t   day_reg;

    rdd_pkg::ord_t   y365_next;
    logic [12:0]     q4_next;
    logic [7:0]      q100_next;
    logic [5:0]      q400_next;
    logic [7:0]      qy100_next;
    logic [27:0]     p99;
    logic [27:0]     p399;
    logic [27:0]     py;
    logic [15:0]     y3;

    rdd_pkg::year_t  hundreds;
    logic            leap;
    rdd_pkg::ord_t   ord_next;

    always_comb
    begin
        y365_next  = 23'({8'd0, year} * 23'd365);
        y3         = {1'b0, year} + 16'd3;
        q4_next    = 13'(y3 >> 2);
        // Division by 100 and 400 through a scaled reciprocal.
        p99        = 28'(year + 15'd99) * 28'(rdd_pkg::RECIP100);
        p399       = 28'(year + 15'd399) * 28'(rdd_pkg::RECIP100);
        py         = 28'(year) * 28'(rdd_pkg::RECIP100);
        q100_next  = 8'(p99 >> rdd_pkg::RECIP_SHF);
        q400_next  = 6'(p399 >> (rdd_pkg::RECIP_SHF + 2));
        qy100_next = 8'(py >> rdd_pkg::RECIP_SHF);
    end

    always_ff @(posedge clk)
    begin
        if (load_a)
        begin
            y365_reg  <= y365_next;
            q4_reg    <= q4_next;
            q100_reg  <= q100_next;
            q400_reg  <= q400_next;
            qy100_reg <= qy100_next;
            year_reg  <= year;
            cum_reg   <= rdd_pkg::cum_days(month);
            late_reg  <= (month > rdd_pkg::MONTH_FEB);
            day_reg   <= day;
        end
    end

    always_comb
    begin
        hundreds = 15'({7'd0, qy100_reg} * 15'd100);
        // A century year is a leap year only when its century count is a
        // multiple of four.
        leap = (year_reg[1:0] == 2'd0)
            && ((hundreds != year_reg) || (qy100_reg[1:0] == 2'd0));
        ord_next = y365_reg + 23'(q4_reg) - 23'(q100_reg) + 23'(q400_reg)
                 + 23'(cum_reg) + 23'(leap && late_reg) + 23'(day_reg);
    end

    always_ff @(posedge clk)
    begin
        if (load_b)
        begin
            ord_reg <= ord_next;
        end
    end

endmodule

`default_nettype wire

// File: src/rdd_result.sv
// ----------------------------------------------------------------------------
// rdd_result
// Last stage: ordinal difference, saturation and the expired flag.
// ----------------------------------------------------------------------------
`default_nettype none

module rdd_result
(
    input  wire logic            clk,
    input  wire logic            load,
    input  wire logic [1:0]      op,
    input  wire logic [2:0]      week_days,
    input  wire rdd_pkg::ord_t   due_ord,
    input  wire rdd_pkg::ord_t   cur_ord,
    output rdd_pkg::days_t       days_reg,
    output logic                 expired_reg
);

    logic signed [23:0] diff;
    rdd_pkg::days_t     sat;
    rdd_pkg::days_t     days_next;
    logic               expired_next;

    always_comb
    begin
        diff = signed'({1'b0, due_ord}) - signed'({1'b0, cur_ord});
        if (diff[23] != diff[22])
        begin
            sat = diff[23] ? rdd_pkg::DAYS_MIN : rdd_pkg::DAYS_MAX;
        end
        else
        begin
            sat = diff[22:0];
        end

        unique case (op)
            rdd_pkg::OP_ONCE:
            begin
                days_next    = sat;
                expired_next = sat[22];
            end
            rdd_pkg::OP_WEEKLY:
            begin
                days_next    = 23'(week_days);
                expired_next = 1'b0;
            end
            default:
            begin
                days_next    = sat;
                expired_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            days_reg    <= days_next;
            expired_reg <= expired_next;
        end
    end

endmodule

`default_nettype wire

// File: src/reminder_days_until_date_core.sv
// ----------------------------------------------------------------------------
// reminder_days_until_date_core
// Signed day count from today to a reminder's next due date, Gregorian rule.
// ----------------------------------------------------------------------------
//
//   Channel | Handshake            | Payload
//   --------+----------------------+-------------------------------------------
//   in      | in_valid / in_ready  | op, cur_*, tgt_* date and weekday fields
//   out     | out_valid / out_ready| days, expired
//
// Four register stages: due-date select, ordinal year terms, ordinal sum,
// difference with saturation.
// One beat is taken every cycle while the output side keeps up.
// A stage loads whenever it is empty or its successor moves, so bubbles close
// up and a full pipe holds in place while out_ready is low.
// Reset clears only the stage valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module reminder_days_until_date_core
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         op,
    input  wire logic [13:0]        cur_year,
    input  wire logic [3:0]         cur_month,
    input  wire logic [4:0]         cur_day,
    input  wire logic [2:0]         cur_weekday,
    input  wire logic [13:0]        tgt_year,
    input  wire logic [3:0]         tgt_month,
    input  wire logic [4:0]         tgt_day,
    input  wire logic [2:0]         tgt_weekday,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [22:0]      days,
    output logic                    expired
);

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic v1_next, v2_next, v3_next, v4_next;
    logic ld1, ld2, ld3, ld4;

    rdd_pkg::sel_t  sel_reg;
    logic [1:0]     op2_reg, op3_reg;
    logic [2:0]     wk2_reg, wk3_reg;
    rdd_pkg::ord_t  due_ord;
    rdd_pkg::ord_t  cur_ord;
    rdd_pkg::days_t days_reg;
    logic           expired_reg;

    always_comb
    begin
        ld4 = !v4_reg || out_ready;
        ld3 = !v3_reg || ld4;
        ld2 = !v2_reg || ld3;
        ld1 = !v1_reg || ld2;
        v1_next = ld1 ? in_valid : v1_reg;
        v2_next = ld2 ? v1_reg   : v2_reg;
        v3_next = ld3 ? v2_reg   : v3_reg;
        v4_next = ld4 ? v3_reg   : v4_reg;
    end

    assign in_ready  = ld1;
    assign out_valid = v4_reg;
    assign days      = days_reg;
    assign expired   = expired_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    // Rule and weekly answer ride alongside the ordinal stages.
    always_ff @(posedge clk)
    begin
        if (ld2)
        begin
            op2_reg <= sel_reg.op;
            wk2_reg <= sel_reg.week_days;
        end
        if (ld3)
        begin
            op3_reg <= op2_reg;
            wk3_reg <= wk2_reg;
        end
    end

    rdd_select u_select
    (
        .clk         (clk),
        .load        (ld1),
        .op          (op),
        .cur_year    (cur_year),
        .cur_month   (cur_month),
        .cur_day     (cur_day),
        .cur_weekday (cur_weekday),
        .tgt_year    (tgt_year),
        .tgt_month   (tgt_month),
        .tgt_day     (tgt_day),
        .tgt_weekday (tgt_weekday),
        .sel_reg     (sel_reg)
    );

    rdd_ordinal u_due_ord
    (
        .clk     (clk),
        .load_a  (ld2),
        .load_b  (ld3),
        .year    (sel_reg.due_year),
        .month   (sel_reg.due_month),
        .day     (sel_reg.due_day),
        .ord_reg (due_ord)
    );

    rdd_ordinal u_cur_ord
    (
        .clk     (clk),
        .load_a  (ld2),
        .load_b  (ld3),
        .year    (sel_reg.cur_year),
        .month   (sel_reg.cur_month),
        .day     (sel_reg.cur_day),
        .ord_reg (cur_ord)
    );

    rdd_result u_result
    (
        .clk         (clk),
        .load        (ld4),
        .op          (op3_reg),
        .week_days   (wk3_reg),
        .due_ord     (due_ord),
        .cur_ord     (cur_ord),
        .days_reg    (days_reg),
        .expired_reg (expired_reg)
    );

    // An empty first stage always takes a beat.
    a_empty_takes: assert property (@(posedge clk) disable iff (!rst_n)
        !v1_reg |-> in_ready)
        else $error("first stage empty but input not ready");

    // A beat that is accepted shows up in the first stage.
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> v1_reg)
        else $error("accepted beat lost at first stage");

    // A full pipe under back-pressure keeps every stage occupied.
    a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg && v2_reg && v3_reg && v4_reg && !out_ready
        |=> v1_reg && v2_reg && v3_reg && v4_reg)
        else $error("stalled pipe dropped a beat");

    // Expired only comes with a negative day count.
    a_expired_neg: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && expired |-> days[22])
        else $error("expired set on a non-negative day count");

endmodule

`default_nettype wire

// File: dv/tb_reminder_days_until_date_core.sv
// ----------------------------------------------------------------------------
// tb_reminder_days_until_date_core
// Self-checking bench for the days-until-date core. A clocked driver sends
// date beats in random bursts from a queue that the stimulus block fills.
// A clocked monitor takes result beats under a changing stall pattern and
// checks each one against a prediction made when the input beat was sent.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_reminder_days_until_date_core;

    typedef struct {
        logic [1:0]  op;
        logic [13:0] cur_year;
        logic [3:0]  cur_month;
        logic [4:0]  cur_day;
        logic [2:0]  cur_weekday;
        logic [13:0] tgt_year;
        logic [3:0]  tgt_month;
        logic [4:0]  tgt_day;
        logic [2:0]  tgt_weekday;
        bit          drain;
    } reminder_t;

    typedef struct {
        logic signed [22:0] days;
        logic               expired;
    } due_t;

    localparam int MONTH_LEN [13] = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    localparam longint SAT_HI = 64'sd4194303;
    localparam longint SAT_LO = -64'sd4194304;

    localparam int RX_FREE   = 0;
    localparam int RX_COIN   = 1;
    localparam int RX_SPARSE = 2;
    localparam int RX_CYCLIC = 3;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [1:0]         op = '0;
    logic [13:0]        cur_year = '0;
    logic [3:0]         cur_month = '0;
    logic [4:0]         cur_day = '0;
    logic [2:0]         cur_weekday = '0;
    logic [13:0]        tgt_year = '0;
    logic [3:0]         tgt_month = '0;
    logic [4:0]         tgt_day = '0;
    logic [2:0]         tgt_weekday = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [22:0] days;
    logic               expired;

    reminder_t pending_dates [$];
    due_t      due_queue [$];
    due_t      driven_due;
    int        mismatches = 0;
    int        burst_left = 0;
    int        gap_left = 0;
    int        rx_mode = RX_FREE;
    int        rx_left = 0;
    int        rx_cycle = 0;

    reminder_days_until_date_core DUT
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .cur_year    (cur_year),
        .cur_month   (cur_month),
        .cur_day     (cur_day),
        .cur_weekday (cur_weekday),
        .tgt_year    (tgt_year),
        .tgt_month   (tgt_month),
        .tgt_day     (tgt_day),
        .tgt_weekday (tgt_weekday),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .days        (days),
        .expired     (expired)
    );

    always #1 clk = ~clk;

    // Day count since day zero of January in year zero; months are already clamped.
    function automatic longint day_number(input longint y, input int m, input int d);
        longint n;
        int     i;
        n = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
        for (i = 1; i < m; i++)
        begin
            n += MONTH_LEN[i];
        end
        if (m > 2 && ((y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0))))
        begin
            n += 1;
        end
        return n + d;
    endfunction

    function automatic due_t predict_due(input reminder_t it);
        due_t   r;
        longint today;
        longint delta;
        longint yy;
        int     cm;
        int     tm;
        int     mm;
        int     cw;
        int     tw;
        cm = (it.cur_month == 0) ? 1 : ((it.cur_month > 12) ? 12 : int'(it.cur_month));
        tm = (it.tgt_month == 0) ? 1 : ((it.tgt_month > 12) ? 12 : int'(it.tgt_month));
        cw = int'(it.cur_weekday);
        tw = int'(it.tgt_weekday);
        today = day_number(longint'(it.cur_year), cm, int'(it.cur_day));
        r.expired = 1'b0;
        case (it.op)
            rdd_pkg::OP_ONCE:
            begin
                delta = day_number(longint'(it.tgt_year), tm, int'(it.tgt_day)) - today;
                r.expired = (delta < 0);
            end
            rdd_pkg::OP_WEEKLY:
            begin
                delta = ((tw % 7) + 7 - (cw % 7)) % 7;
            end
            rdd_pkg::OP_MONTHLY:
            begin
                yy = longint'(it.cur_year);
                mm = cm;
                if (it.cur_day > it.tgt_day)
                begin
                    if (mm == 12)
                    begin
                        mm = 1;
                        yy = yy + 1;
                    end
                    else
                    begin
                        mm = mm + 1;
                    end
                end
                delta = day_number(yy, mm, int'(it.tgt_day)) - today;
            end
            default:
            begin
                yy = longint'(it.cur_year);
                if (cm > tm || (cm == tm && it.cur_day > it.tgt_day))
                begin
                    yy = yy + 1;
                end
                delta = day_number(yy, tm, int'(it.tgt_day)) - today;
            end
        endcase
        if (delta > SAT_HI)
        begin
            delta = SAT_HI;
        end
        if (delta < SAT_LO)
        begin
            delta = SAT_LO;
        end
        r.days = delta[22:0];
        return r;
    endfunction

    function automatic reminder_t dated(input logic [1:0] o,
                                        input int cy, input int cm, input int cd, input int cw,
                                        input int ty, input int tm, input int td, input int tw);
        reminder_t it;
        it.op          = o;
        it.cur_year    = 14'(cy);
        it.cur_month   = 4'(cm);
        it.cur_day     = 5'(cd);
        it.cur_weekday = 3'(cw);
        it.tgt_year    = 14'(ty);
        it.tgt_month   = 4'(tm);
        it.tgt_day     = 5'(td);
        it.tgt_weekday = 3'(tw);
        it.drain       = 1'b0;
        return it;
    endfunction

    // Driver: holds a beat until it is taken, then sends the next one or idles.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!(in_valid && !in_ready))
        begin
            if (in_valid)
            begin
                due_queue.push_back(driven_due);
            end
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (pending_dates.size() > 0 && pending_dates[0].drain)
            begin
                // Hold off until every outstanding result has come back.
                if (due_queue.size() == 0)
                begin
                    void'(pending_dates.pop_front());
                end
                in_valid <= 1'b0;
            end
            else if (pending_dates.size() > 0)
            begin
                reminder_t it;
                it = pending_dates.pop_front();
                driven_due  = predict_due(it);
                op          <= it.op;
                cur_year    <= it.cur_year;
                cur_month   <= it.cur_month;
                cur_day     <= it.cur_day;
                cur_weekday <= it.cur_weekday;
                tgt_year    <= it.tgt_year;
                tgt_month   <= it.tgt_month;
                tgt_day     <= it.tgt_day;
                tgt_weekday <= it.tgt_weekday;
                in_valid    <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end
                else
                begin
                    burst_left--;
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver stall pattern: switches between free running, coin flips,
    // rare acceptance and a fixed cycle.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (rx_left == 0)
            begin
                rx_mode = $urandom_range(RX_FREE, RX_CYCLIC);
                rx_left = $urandom_range(20, 300);
            end
            else
            begin
                rx_left--;
            end
            rx_cycle++;
            case (rx_mode)
                RX_FREE:   out_ready <= 1'b1;
                RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
                default:   out_ready <= (rx_cycle % 5 < 2);
            endcase
        end
    end

    // Monitor: every result beat is checked against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (due_queue.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result beat, days %0d expired %0b",
                         $time, days, expired);
            end
            else
            begin
                due_t want;
                want = due_queue.pop_front();
                if (days !== want.days)
                begin
                    mismatches++;
                    $display("%0t: days mismatch, expected %0d, actual %0d",
                             $time, want.days, days);
                end
                if (expired !== want.expired)
                begin
                    mismatches++;
                    $display("%0t: expired mismatch, expected %0b, actual %0b",
                             $time, want.expired, expired);
                end
            end
        end
    end

    initial
    begin
        reminder_t it;
        int        cy;
        int        ty;
        int        pick;
        int        i;

        // Directed beats: range ends, every rule and the corner cases.
        pending_dates.push_back(dated(rdd_pkg::OP_ONCE, 2024, 5, 10, 5, 2024, 5, 10, 5));
        pending_dates.push_back(dated(rdd_pkg::OP_ONCE, 2024, 5, 10, 5, 2023, 12, 31, 7));
        pending_dates.push_back(dated(rdd_pkg::OP_ONCE, 1, 1, 1, 1, 9999, 12, 31, 5));
        pending_dates.push_back(dated(rdd_pkg::OP_ONCE, 9999, 12, 31, 5, 1, 1, 1, 1));
        pending_dates.push_back(dated(rdd_pkg::OP_ONCE, 0, 0, 0, 0, 16383, 15, 31, 7));
        pending_dates.push_back(dated(rdd_pkg::OP_ONCE, 16383, 15, 31, 7, 0, 0, 0, 0));
        pending_dates.push_back(dated(rdd_pkg::OP_ONCE, 2023, 2, 29, 3, 2023, 3, 1, 3));
        pending_dates.push_back(dated(rdd_pkg::OP_ONCE, 0, 2, 29, 2, 1, 1, 0, 1));
        pending_dates.push_back(dated(rdd_pkg::OP_WEEKLY, 2024, 1, 1, 7, 2020, 6, 6, 1));
        pending_dates.push_back(dated(rdd_pkg::OP_WEEKLY, 2024, 1, 1, 1, 2020, 6, 6, 7));
        pending_dates.push_back(dated(rdd_pkg::OP_WEEKLY, 2024, 1, 1, 0, 2020, 6, 6, 7));
        pending_dates.push_back(dated(rdd_pkg::OP_WEEKLY, 2024, 1, 1, 3, 2024, 1, 1, 3));
        pending_dates.push_back(dated(rdd_pkg::OP_MONTHLY, 2023, 12, 20, 3, 1900, 4, 5, 1));
        pending_dates.push_back(dated(rdd_pkg::OP_MONTHLY, 2023, 12, 5, 2, 1900, 4, 20, 1));
        pending_dates.push_back(dated(rdd_pkg::OP_MONTHLY, 2023, 1, 31, 2, 1900, 4, 30, 1));
        pending_dates.push_back(dated(rdd_pkg::OP_MONTHLY, 2024, 15, 1, 2, 1900, 4, 0, 1));
        pending_dates.push_back(dated(rdd_pkg::OP_MONTHLY, 16383, 12, 31, 7, 0, 0, 1, 0));
        pending_dates.push_back(dated(rdd_pkg::OP_YEARLY, 2023, 6, 15, 4, 1800, 3, 1, 1));
        pending_dates.push_back(dated(rdd_pkg::OP_YEARLY, 2023, 2, 10, 5, 1800, 11, 30, 1));
        pending_dates.push_back(dated(rdd_pkg::OP_YEARLY, 2023, 1, 5, 4, 2000, 2, 29, 2));
        pending_dates.push_back(dated(rdd_pkg::OP_YEARLY, 2023, 7, 4, 2, 2001, 7, 4, 3));
        pending_dates.push_back(dated(rdd_pkg::OP_YEARLY, 0, 0, 9, 6, 1, 0, 3, 1));
        pending_dates.push_back(dated(rdd_pkg::OP_YEARLY, 16383, 12, 31, 7, 5, 15, 30, 2));

        // Random beats: mostly calendar-sane dates, some near each other,
        // some with every field drawn over its full width.
        for (i = 0; i < 1600; i++)
        begin
            if (i == 400 || i == 1100)
            begin
                it.drain = 1'b1;
                pending_dates.push_back(it);
            end
            pick = $urandom_range(0, 9);
            cy = $urandom_range(1, 9999);
            ty = $urandom_range(1, 9999);
            if (pick < 3)
            begin
                ty = cy + $urandom_range(0, 4) - 2;
                ty = (ty < 1) ? 1 : ((ty > 9999) ? 9999 : ty);
            end
            it = dated(2'($urandom_range(0, 3)),
                       cy, $urandom_range(1, 12),
                       ($urandom_range(0, 2) == 0) ? $urandom_range(1, 31) : $urandom_range(1, 28),
                       $urandom_range(1, 7),
                       ty, $urandom_range(1, 12),
                       ($urandom_range(0, 2) == 0) ? $urandom_range(1, 31) : $urandom_range(1, 28),
                       $urandom_range(1, 7));
            if (pick == 9)
            begin
                it.cur_year    = 14'($urandom);
                it.cur_month   = 4'($urandom);
                it.cur_day     = 5'($urandom);
                it.cur_weekday = 3'($urandom);
                it.tgt_year    = 14'($urandom);
                it.tgt_month   = 4'($urandom);
                it.tgt_day     = 5'($urandom);
                it.tgt_weekday = 3'($urandom);
            end
            pending_dates.push_back(it);
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Checked away from the rising edge so the driver's updates have settled.
        while (pending_dates.size() != 0 || in_valid)
        begin
            @(negedge clk);
        end
        while (due_queue.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (12) @(posedge clk);

        if (mismatches == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

    initial
    begin
        #2000000;
        $display("status: fail");
        $finish;
    end

endmodule

// File: files.f
src/rdd_pkg.sv
src/rdd_select.sv
src/rdd_ordinal.sv
src/rdd_result.sv
src/reminder_days_until_date_core.sv
dv/tb_reminder_days_until_date_core.sv
